@@ rtl/event_timer_min_scheduler_core_macros.svh @@
// Assertion macros for the event timer min scheduler core.
// Used by the core module; they expect clk_i and rst_ni in scope.
`ifndef EVENT_TIMER_MIN_SCHEDULER_CORE_MACROS_SVH
`define EVENT_TIMER_MIN_SCHEDULER_CORE_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define ETMS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define ETMS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/etms_pkg.sv @@
// Package for the event timer min scheduler core.
// Holds request codes, state encoding and fixed field widths; no dependencies.
`default_nettype none

package etms_pkg;

  localparam int unsigned ReqWidth    = 3;
  localparam int unsigned IdxWidth    = 5;
  localparam int unsigned AmountWidth = 32;
  localparam int unsigned FreqWidth   = 8;
  localparam int unsigned RemWidth    = 64;
  localparam int unsigned InDataWidth  = 40;
  localparam int unsigned OutDataWidth = 72;
  localparam int unsigned TickShift    = 3;

  localparam logic [FreqWidth-1:0] FreqReset = 8'd25;

  typedef enum logic [ReqWidth-1:0] {
    REQ_ARM_CYCLES = 3'd0,
    REQ_ARM_TICKS  = 3'd1,
    REQ_ARM_US     = 3'd2,
    REQ_REMOVE     = 3'd3,
    REQ_ACK        = 3'd4,
    REQ_ADVANCE    = 3'd5,
    REQ_QUERY      = 3'd6
  } etms_req_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_SWEEP  = 4'b0100,
    ST_RESULT = 4'b1000
  } etms_state_e;

endpackage

`default_nettype wire

@@ rtl/event_timer_min_scheduler_core.sv @@
// Event timer min scheduler core: one-shot timer table with a deadline memory.
// Depends on etms_pkg and event_timer_min_scheduler_core_macros.svh.
//
// Channel   Direction  Transfer when             Contents
// s_axis    in         tvalid && tready          tuser req_type, tdata index/amount
// m_axis    out        tvalid && tready          status of the table after the item
// cfg       in         cfg_we_i                  cpu_freq_mhz
//
// Advance, query and requests naming the null entry go from execution straight
// to the result. Arm, remove and acknowledge first sweep the deadline memory,
// one entry per cycle through its single read and single write port. Reset
// clears the armed bits and the countdown; the deadline memory needs no
// clearing pass. One item is in work at a time; a new item is taken while the
// last result waits on m_axis.
`default_nettype none

module event_timer_min_scheduler_core #(
  parameter int unsigned NUM_EVENTS = 32,
  parameter int unsigned TIME_WIDTH = 64
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [etms_pkg::FreqWidth-1:0]        cfg_wdata_i,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // Fields from bit 0: event_index[4:0], amount[36:5], zero padding[39:37].
  input  wire logic [etms_pkg::InDataWidth-1:0]      s_axis_tdata,
  // Fields from bit 0: req_type[2:0].
  input  wire logic [etms_pkg::ReqWidth-1:0]         s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // Fields from bit 0: active_event[4:0], remaining_cycles[68:5], fire[69],
  // event_armed[70], zero padding[71].
  output logic [etms_pkg::OutDataWidth-1:0]          m_axis_tdata
);

  import etms_pkg::*;

  localparam int unsigned IW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned EW = TIME_WIDTH + 2;

  localparam logic [63:0] MaxT64 = (64'd1 << (TIME_WIDTH - 1)) - 64'd1;
  localparam logic signed [TW-1:0] MaxT = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [EW-1:0] MaxTExt = {3'b000, {(TW-1){1'b1}}};
  localparam logic signed [EW-1:0] MinTExt = {3'b111, {(TW-1){1'b0}}};

  function automatic logic signed [TW-1:0] sat_sub(input logic signed [EW-1:0] a,
                                                   input logic signed [EW-1:0] b);
    logic signed [EW-1:0] diff;
    diff = a - b;
    if (diff > MaxTExt) begin
      sat_sub = MaxT;
    end else if (diff < MinTExt) begin
      sat_sub = ~MaxT;
    end else begin
      sat_sub = TW'(diff);
    end
  endfunction

  etms_state_e state_q, state_d;

  logic [FreqWidth-1:0]   freq_q;
  logic [ReqWidth-1:0]    req_q;
  logic [IdxWidth-1:0]    idx_q;
  logic [AmountWidth-1:0] amount_q;

  logic [NUM_EVENTS-1:0]  armed_q, armed_d;
  logic [IW-1:0]          cur_q, cur_d;
  logic signed [TW-1:0]   pending_q, pending_d;
  logic signed [TW-1:0]   cur_dl_q, cur_dl_d;

  logic                   op_arm_q, op_arm_d;
  logic                   op_clr_q, op_clr_d;
  logic [IW-1:0]          tgt_q, tgt_d;
  logic signed [TW-1:0]   delay_q, delay_d;
  logic signed [TW-1:0]   elapsed_q, elapsed_d;

  logic [IW:0]            rd_cnt_q, rd_cnt_d;
  logic                   s1_v_q, s1_v_d;
  logic [IW-1:0]          s1_idx_q;
  logic                   s2_v_q, s2_v_d;
  logic [IW-1:0]          s2_idx_q;
  logic                   s2_a_q;
  logic signed [TW-1:0]   s2_d_q;
  logic signed [TW-1:0]   best_q, best_d;
  logic [IW-1:0]          pick_q, pick_d;

  logic signed [TW-1:0]   mem_q [NUM_EVENTS];
  logic signed [TW-1:0]   rd_data_q;
  logic                   mem_we;
  logic signed [TW-1:0]   d_new;
  logic                   a_new;
  logic signed [TW-1:0]   d_fold;

  logic                   m_valid_q, m_valid_d;
  logic [OutDataWidth-1:0] m_data_q, m_data_d;

  logic                   in_xfer;
  logic                   valid_idx;
  logic [39:0]            prod;
  logic [39:0]            raw_delay;
  logic                   issue;
  logic                   out_load;
  logic signed [TW-1:0]   rem;
  logic                   fire;
  logic                   armed_out;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign valid_idx     = (idx_q != '0) && (32'(idx_q) < NUM_EVENTS);
  assign prod          = 40'(amount_q) * 40'(freq_q);
  assign issue         = (state_q == ST_SWEEP) && (32'(rd_cnt_q) < NUM_EVENTS);

  always_comb begin
    case (req_q)
      REQ_ARM_TICKS: raw_delay = prod >> TickShift;
      REQ_ARM_US:    raw_delay = prod;
      default:       raw_delay = 40'(amount_q);
    endcase
    if (64'(raw_delay) > MaxT64) begin
      delay_d = MaxT;
    end else begin
      delay_d = TW'(raw_delay);
    end
  end

  always_comb begin
    d_fold = armed_q[s1_idx_q] ? sat_sub(EW'(rd_data_q), EW'(elapsed_q)) : rd_data_q;
    d_new  = d_fold;
    a_new  = armed_q[s1_idx_q];
    if (op_arm_q && (s1_idx_q == tgt_q)) begin
      d_new = delay_q;
      a_new = 1'b1;
    end else if (op_clr_q && (s1_idx_q == tgt_q)) begin
      a_new = 1'b0;
    end
    mem_we = s1_v_q;
  end

  assign rem       = (cur_q != '0) ? pending_q : MaxT;
  assign fire      = (cur_q != '0) && (pending_q[TW-1] || (pending_q == '0));
  assign armed_out = (req_q == REQ_QUERY) && valid_idx && armed_q[IW'(idx_q)];
  assign out_load  = (state_q == ST_RESULT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d   = state_q;
    armed_d   = armed_q;
    cur_d     = cur_q;
    pending_d = pending_q;
    cur_dl_d  = cur_dl_q;
    op_arm_d  = op_arm_q;
    op_clr_d  = op_clr_q;
    tgt_d     = tgt_q;
    elapsed_d = (cur_q != '0) ? sat_sub(EW'(cur_dl_q), EW'(pending_q)) : '0;
    rd_cnt_d  = rd_cnt_q;
    s1_v_d    = issue;
    s2_v_d    = s1_v_q;
    best_d    = best_q;
    pick_d    = pick_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;

    if (s1_v_q) begin
      armed_d[s1_idx_q] = a_new;
    end
    if (s2_v_q && s2_a_q && (s2_idx_q != '0) && (s2_d_q < best_q)) begin
      best_d = s2_d_q;
      pick_d = s2_idx_q;
    end
    if (issue) begin
      rd_cnt_d = rd_cnt_q + 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        op_arm_d = 1'b0;
        op_clr_d = 1'b0;
        tgt_d    = IW'(idx_q);
        rd_cnt_d = '0;
        best_d   = MaxT;
        pick_d   = '0;
        state_d  = ST_RESULT;
        case (req_q)
          REQ_ARM_CYCLES, REQ_ARM_TICKS, REQ_ARM_US: begin
            if (valid_idx) begin
              op_arm_d = 1'b1;
              state_d  = ST_SWEEP;
            end
          end
          REQ_REMOVE: begin
            if (valid_idx) begin
              op_clr_d = 1'b1;
              state_d  = ST_SWEEP;
            end
          end
          REQ_ACK: begin
            op_clr_d = (cur_q != '0);
            tgt_d    = cur_q;
            state_d  = ST_SWEEP;
          end
          REQ_ADVANCE: begin
            if (cur_q != '0) begin
              pending_d = sat_sub(EW'(pending_q),
                                  $signed({{(EW-AmountWidth){1'b0}}, amount_q}));
            end
          end
          default: begin
          end
        endcase
      end
      ST_SWEEP: begin
        if (!issue && !s1_v_q && !s2_v_q) begin
          cur_d     = pick_q;
          pending_d = best_q;
          cur_dl_d  = best_q;
          state_d   = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      m_valid_d = 1'b1;
      m_data_d  = {1'b0, armed_out, fire, RemWidth'(rem), IdxWidth'(cur_q)};
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      freq_q    <= FreqReset;
      armed_q   <= '0;
      cur_q     <= '0;
      pending_q <= '0;
      cur_dl_q  <= MaxT;
      op_arm_q  <= 1'b0;
      op_clr_q  <= 1'b0;
      rd_cnt_q  <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) begin
        freq_q <= cfg_wdata_i;
      end
      armed_q   <= armed_d;
      cur_q     <= cur_d;
      pending_q <= pending_d;
      cur_dl_q  <= cur_dl_d;
      op_arm_q  <= op_arm_d;
      op_clr_q  <= op_clr_d;
      rd_cnt_q  <= rd_cnt_d;
      s1_v_q    <= s1_v_d;
      s2_v_q    <= s2_v_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q    <= s_axis_tuser;
      idx_q    <= s_axis_tdata[IdxWidth-1:0];
      amount_q <= s_axis_tdata[IdxWidth +: AmountWidth];
    end
    if (state_q == ST_EXEC) begin
      delay_q   <= delay_d;
      elapsed_q <= elapsed_d;
    end
    tgt_q    <= tgt_d;
    s1_idx_q <= rd_cnt_q[IW-1:0];
    s2_idx_q <= s1_idx_q;
    s2_a_q   <= a_new;
    s2_d_q   <= d_new;
    best_q   <= best_d;
    pick_q   <= pick_d;
    m_data_q <= m_data_d;
  end

  // The sweep reads entry i while entry i-1 is written back, so the read and
  // write ports never address the same entry in one cycle.
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_cnt_q[IW-1:0]];
    if (mem_we) begin
      mem_q[s1_idx_q] <= d_new;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`include "event_timer_min_scheduler_core_macros.svh"

  `ETMS_ASSERT(a_accept_pipe_empty, in_xfer |-> !s1_v_q && !s2_v_q, "item taken during sweep")
  `ETMS_ASSERT(a_cur_armed, (state_q == ST_IDLE) && (cur_q != '0) |-> armed_q[cur_q], "active entry not armed")
  `ETMS_ASSERT(a_fire_has_event, m_valid_q && m_data_q[RemWidth+IdxWidth] |-> m_data_q[IdxWidth-1:0] != '0, "fire without active entry")
  `ETMS_ASSERT(a_stage_order, s2_v_q |-> $past(s1_v_q), "second stage without first")
  `ETMS_ASSERT_ALWAYS(a_cnt_bound, 32'(rd_cnt_q) <= NUM_EVENTS, "sweep counter beyond table")

endmodule

`default_nettype wire
